// ===== sv/rld_pkg.sv =====
// Shared types and constants for the run-length decoder.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package rld_pkg;

  localparam int CharW = 8;
  localparam int CntW  = 6;
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [CharW-1:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;  // 'z'
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'
  localparam int               Radix   = 10;

  // One run to expand: a letter, how many times, and its flags.
  typedef struct packed {
    logic [CharW-1:0] letter;
    logic [CntW-1:0]  times;
    logic             clipped;
    logic             last;
  } run_cmd_t;

endpackage

`default_nettype wire

// ===== sv/rld_if.sv =====
// Handshake channels of the run-length decoder: character in, letter out.
// Depends on rld_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rld_in_if;
  logic                        valid;
  logic                        ready;
  logic [rld_pkg::CharW-1:0]   char_in;
  logic                        string_end;

  modport source(output valid, char_in, string_end, input ready);
  modport sink(input valid, char_in, string_end, output ready);
endinterface

interface rld_out_if;
  logic                        valid;
  logic                        ready;
  logic [rld_pkg::CharW-1:0]   char_out;
  logic                        run_last;
  logic                        count_clipped;

  modport source(output valid, char_out, run_last, count_clipped, input ready);
  modport sink(input valid, char_out, run_last, count_clipped, output ready);
endinterface

`default_nettype wire

// ===== sv/run_length_decoder.sv =====
// Channel   | Dir | Fields                              | Beat
// in_i      | in  | char_in[7:0], string_end            | one character
// out_o     | out | char_out[7:0], run_last, count_clipped | one decoded letter
//
// The front takes one character per cycle while the two-entry run queue has room;
// a letter that ends the string while another letter is pending holds the input
// until its second run command has been pushed, which waits while the queue is full.
// The back emits one letter per cycle while the receiver is ready, one per repeat,
// and the sustained rate follows the average run length.
// Reset clears the pending letter, the count and the queue; no clearing pass.
// Either side may stall on its own; the queue decouples them.
// Depends on rld_pkg, rld_if, rld_front, rld_queue and rld_back.
`timescale 1ns / 1ps
`default_nettype none

module run_length_decoder #(
  parameter int MAX_COUNT = 63
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  rld_in_if.sink         in_i,
  rld_out_if.source      out_o
);

  logic                  q_ready;
  logic                  push;
  rld_pkg::run_cmd_t     push_cmd;
  logic                  pop;
  logic                  q_valid;
  rld_pkg::run_cmd_t     q_cmd;

  rld_front #(
    .MAX_COUNT(MAX_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  rld_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  rld_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== sv/rld_front.sv =====
// Front end: takes characters, tracks the pending letter and its count,
// and issues run commands to the queue. Depends on rld_pkg and rld_if.
`timescale 1ns / 1ps
`default_nettype none

module rld_front #(
  parameter int MAX_COUNT = 63
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  rld_in_if.sink                 in_i,
  input  wire                    q_ready_i,
  output logic                   push_o,
  output rld_pkg::run_cmd_t      push_cmd_o
);

  localparam logic [rld_pkg::CntW-1:0] MaxCnt = rld_pkg::CntW'(MAX_COUNT);
  localparam int ProdW = rld_pkg::CntW + 4;

  logic [rld_pkg::CharW-1:0] letter_q, letter_d;
  logic                      lvalid_q, lvalid_d;
  logic [rld_pkg::CntW-1:0]  count_q, count_d;
  logic                      digits_q, digits_d;
  logic                      ovf_q, ovf_d;
  logic                      second_q, second_d;
  rld_pkg::run_cmd_t         second_cmd_q, second_cmd_d;

  logic                      accept;
  logic                      is_letter;
  logic                      is_digit;
  logic [ProdW-1:0]          acc_val;
  logic [rld_pkg::CntW-1:0]  eff_count;
  logic                      eff_digits;
  logic                      eff_ovf;
  logic                      flush_old;
  rld_pkg::run_cmd_t         cmd_old;
  rld_pkg::run_cmd_t         cmd_new;

  assign in_i.ready = q_ready_i && !second_q;
  assign accept     = in_i.valid && in_i.ready;

  assign is_letter = (in_i.char_in >= rld_pkg::ChLowA) && (in_i.char_in <= rld_pkg::ChLowZ);
  assign is_digit  = (in_i.char_in >= rld_pkg::ChZero) && (in_i.char_in <= rld_pkg::ChNine);

  // count * 10 + digit, as two shifts and adds.
  assign acc_val = (ProdW'(count_q) << 3) + (ProdW'(count_q) << 1)
                 + ProdW'(in_i.char_in - rld_pkg::ChZero);

  // A digit on the last character still counts before the flush.
  always_comb begin
    eff_count  = count_q;
    eff_digits = digits_q;
    eff_ovf    = ovf_q;
    if (is_digit && lvalid_q) begin
      eff_digits = 1'b1;
      if (acc_val > ProdW'(MaxCnt)) begin
        eff_count = MaxCnt;
        eff_ovf   = 1'b1;
      end else begin
        eff_count = acc_val[rld_pkg::CntW-1:0];
      end
    end
  end

  assign flush_old = lvalid_q && (is_letter || in_i.string_end);

  always_comb begin
    cmd_old.letter  = letter_q;
    cmd_old.times   = eff_digits ? eff_count : rld_pkg::CntW'(1);
    cmd_old.clipped = eff_ovf;
    cmd_old.last    = !(is_letter && in_i.string_end);
    cmd_new.letter  = in_i.char_in;
    cmd_new.times   = rld_pkg::CntW'(1);
    cmd_new.clipped = 1'b0;
    cmd_new.last    = 1'b1;
  end

  always_comb begin
    letter_d     = letter_q;
    lvalid_d     = lvalid_q;
    count_d      = count_q;
    digits_d     = digits_q;
    ovf_d        = ovf_q;
    second_d     = second_q;
    second_cmd_d = second_cmd_q;
    push_o       = 1'b0;
    push_cmd_o   = cmd_old;

    if (second_q) begin
      // The second command waits until the queue has room.
      push_cmd_o = second_cmd_q;
      if (q_ready_i) begin
        push_o   = 1'b1;
        second_d = 1'b0;
      end
    end else if (accept) begin
      // A letter that also ends the string while another letter is pending needs a second command.
      if (flush_old) begin
        push_o     = 1'b1;
        push_cmd_o = cmd_old;
        if (is_letter && in_i.string_end) begin
          second_d     = 1'b1;
          second_cmd_d = cmd_new;
        end
      end else if (is_letter && in_i.string_end) begin
        push_o     = 1'b1;
        push_cmd_o = cmd_new;
      end

      if (in_i.string_end) begin
        letter_d = '0;
        lvalid_d = 1'b0;
        count_d  = '0;
        digits_d = 1'b0;
        ovf_d    = 1'b0;
      end else if (is_letter) begin
        letter_d = in_i.char_in;
        lvalid_d = 1'b1;
        count_d  = '0;
        digits_d = 1'b0;
        ovf_d    = 1'b0;
      end else begin
        count_d  = eff_count;
        digits_d = eff_digits;
        ovf_d    = eff_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q <= '0;
      lvalid_q <= 1'b0;
      count_q  <= '0;
      digits_q <= 1'b0;
      ovf_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      letter_q <= letter_d;
      lvalid_q <= lvalid_d;
      count_q  <= count_d;
      digits_q <= digits_d;
      ovf_q    <= ovf_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    second_cmd_q <= second_cmd_d;
  end

`ifndef NO_ASSERTIONS
  a_second_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !in_i.ready)
    else $error("input taken while a second run command is pending");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("repeat count above its limit");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> q_ready_i)
    else $error("run command pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== sv/rld_queue.sv =====
// Short queue of run commands between the front and back ends.
// Depends on rld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rld_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  rld_pkg::run_cmd_t      push_cmd_i,
  output logic                   ready_o,
  input  wire                    pop_i,
  output logic                   valid_o,
  output rld_pkg::run_cmd_t      cmd_o
);

  localparam int CntBits = $clog2(rld_pkg::QDepth + 1);

  rld_pkg::run_cmd_t             mem_q [rld_pkg::QDepth];
  logic [rld_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]            fill_q;
  logic                          do_push, do_pop;

  assign ready_o = (fill_q != CntBits'(rld_pkg::QDepth));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == rld_pkg::QPtrW'(rld_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == rld_pkg::QPtrW'(rld_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + CntBits'(do_push) - CntBits'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntBits'(rld_pkg::QDepth))
    else $error("queue fill count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");
  a_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("queue fill count missed a push");
`endif

endmodule

`default_nettype wire

// ===== sv/rld_back.sv =====
// Back end: expands each run command into one letter beat per repeat,
// straight from registers. Depends on rld_pkg and rld_if.
`timescale 1ns / 1ps
`default_nettype none

module rld_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    q_valid_i,
  input  rld_pkg::run_cmd_t      q_cmd_i,
  output logic                   pop_o,
  rld_out_if.source              out_o
);

  logic                          busy_q, busy_d;
  logic [rld_pkg::CntW-1:0]      rem_q, rem_d;
  logic [rld_pkg::CharW-1:0]     letter_q;
  logic                          clip_q;
  logic                          last_q;
  logic                          out_fire;
  logic                          final_beat;

  assign out_fire   = out_o.valid && out_o.ready;
  assign final_beat = (rem_q == rld_pkg::CntW'(1));

  // Load the next run as the current one leaves; empty runs are dropped.
  assign pop_o = q_valid_i && (!busy_q || (out_fire && final_beat));

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    if (out_fire) begin
      rem_d = rem_q - 1'b1;
      if (final_beat) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = (q_cmd_i.times != '0);
      rem_d  = q_cmd_i.times;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      letter_q <= q_cmd_i.letter;
      clip_q   <= q_cmd_i.clipped;
      last_q   <= q_cmd_i.last;
    end
  end

  assign out_o.valid         = busy_q;
  assign out_o.char_out      = letter_q;
  assign out_o.count_clipped = clip_q;
  assign out_o.run_last      = last_q && final_beat;

`ifndef NO_ASSERTIONS
  a_busy_has_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0))
    else $error("run active with no beats left");
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !final_beat && !out_fire) |=> (busy_q && $stable(rem_q)))
    else $error("stalled run lost its remaining count");
  a_step_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !final_beat) |=> (rem_q == $past(rem_q) - 1'b1))
    else $error("beat count did not step down");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for run_length_decoder: character beats in, decoded letters out.
// Depends on rld_pkg and the rld_in_if / rld_out_if channel interfaces.
`timescale 1ns / 1ps

module tb;

  localparam int MaxCount    = 63;
  localparam int MaxBeats    = MaxCount + 1;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 32;
  localparam int LimitCycles = 400000;
  localparam int IdlePct     = 13;

  typedef struct packed {
    logic [rld_pkg::CharW-1:0] letter;
    logic                      is_last;
    logic                      clipped;
  } letter_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rld_in_if  in_ch ();
  rld_out_if out_ch ();

  run_length_decoder #(
    .MAX_COUNT(MaxCount)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Decoder state as predicted from the accepted character beats.
  logic [rld_pkg::CharW-1:0] dec_letter;
  logic                      dec_has_letter;
  logic [rld_pkg::CntW-1:0]  dec_count;
  logic                      dec_has_digits;
  logic                      dec_clipped;

  letter_beat_t expected_letters[$];
  letter_beat_t held_beat;
  letter_beat_t exp_beat;
  bit           held_any;
  int           step_beats;

  int  errors = 0;
  int  cycles = 0;
  int  useful_chars = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_fired = 1'b0;
  int  hold_left = 0;

  task automatic clear_decoder();
    dec_letter     = '0;
    dec_has_letter = 1'b0;
    dec_count      = '0;
    dec_has_digits = 1'b0;
    dec_clipped    = 1'b0;
  endtask

  task automatic add_expected(input letter_beat_t b);
    expected_letters.insert(expected_letters.size(), b);
  endtask

  // The newest beat of a step is held back so that it can carry is_last.
  task automatic queue_beat(input letter_beat_t b);
    if (held_any) add_expected(held_beat);
    held_beat = b;
    held_any  = 1'b1;
    step_beats++;
  endtask

  task automatic flush_run();
    int times;
    letter_beat_t b;
    if (!dec_has_letter) return;
    times = dec_has_digits ? int'(dec_count) : 1;
    b.letter  = dec_letter;
    b.is_last = 1'b0;
    b.clipped = dec_clipped;
    for (int k = 0; k < times && step_beats < MaxBeats; k++) queue_beat(b);
    dec_has_letter = 1'b0;
  endtask

  task automatic predict_decode(input logic [rld_pkg::CharW-1:0] ch, input logic is_end);
    int v;
    held_any   = 1'b0;
    step_beats = 0;
    if (ch >= rld_pkg::ChLowA && ch <= rld_pkg::ChLowZ) begin
      flush_run();
      dec_letter     = ch;
      dec_has_letter = 1'b1;
      dec_count      = '0;
      dec_has_digits = 1'b0;
      dec_clipped    = 1'b0;
    end else if (ch >= rld_pkg::ChZero && ch <= rld_pkg::ChNine) begin
      if (dec_has_letter) begin
        v = int'(dec_count) * rld_pkg::Radix + int'(ch - rld_pkg::ChZero);
        if (v > MaxCount) begin
          v = MaxCount;
          dec_clipped = 1'b1;
        end
        dec_count      = v[rld_pkg::CntW-1:0];
        dec_has_digits = 1'b1;
      end
    end
    if (is_end) begin
      flush_run();
      clear_decoder();
    end
    if (held_any) begin
      held_beat.is_last = 1'b1;
      add_expected(held_beat);
    end
  endtask

  // Offers one character beat and returns at the edge where it is taken.
  task automatic send_char(input logic [rld_pkg::CharW-1:0] ch, input logic is_end);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_in    <= ch;
    in_ch.string_end <= is_end;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_decode(ch, is_end);
  endtask

  // A string of letter runs with optional decimal counts, sprinkled with noise.
  task automatic send_random_string();
    logic [rld_pkg::CharW-1:0] chars[$];
    int runs;
    int sel;
    int ndig;
    runs = $urandom_range(1, 5);
    if ($urandom_range(99) < 10) begin
      chars.insert(chars.size(), rld_pkg::CharW'(rld_pkg::ChZero + $urandom_range(9)));
    end
    for (int r = 0; r < runs; r++) begin
      if ($urandom_range(99) < 10) begin
        chars.insert(chars.size(), rld_pkg::CharW'($urandom_range(255)));
      end
      chars.insert(chars.size(), rld_pkg::CharW'(rld_pkg::ChLowA + $urandom_range(25)));
      useful_chars++;
      sel  = $urandom_range(99);
      ndig = (sel < 30) ? 0 : (sel < 80) ? 1 : (sel < 95) ? 2 : 3;
      for (int d = 0; d < ndig; d++) begin
        chars.insert(chars.size(), rld_pkg::CharW'(rld_pkg::ChZero + $urandom_range(9)));
        useful_chars++;
      end
    end
    if ($urandom_range(99) < 8) begin
      chars.insert(chars.size(), rld_pkg::CharW'($urandom_range(255)));
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic test_basic_runs();
    send_char("a", 1'b1);
    send_char("y", 1'b0);
    send_char("5", 1'b0);
    send_char("z", 1'b1);   // flush of y and then z on the same beat
    send_char("7", 1'b0);   // no letter pending yet
    send_char("b", 1'b0);
    send_char("0", 1'b1);   // zero count emits nothing
  endtask

  task automatic test_skipped_chars();
    send_char("c", 1'b0);
    send_char("%", 1'b0);
    send_char("3", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7b, 1'b0);
    send_char(8'h2f, 1'b0);
    send_char(8'h3a, 1'b0);
    send_char(8'hff, 1'b1); // end on a skipped character still flushes
    send_char("9", 1'b1);
  endtask

  task automatic test_count_saturation();
    send_char("q", 1'b0);
    send_char("9", 1'b0);
    send_char("9", 1'b0);
    send_char("m", 1'b0);
    send_char("6", 1'b0);
    send_char("3", 1'b1);   // exactly the maximum, not clipped
    send_char("a", 1'b0);
    send_char("6", 1'b0);
    send_char("4", 1'b1);
  endtask

  task automatic test_random_strings();
    while (useful_chars < 260) send_random_string();
  endtask

  task automatic test_streaming();
    no_idle <= 1'b1;
    while (useful_chars < 360) send_random_string();
    no_idle <= 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_req <= 1'b1;
    while (useful_chars < 420) send_random_string();
    hold_req <= 1'b0;
  endtask

  // Long receiver hold-off, started once per request from the stimulus.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_fired) begin
      hold_left  <= HoldCycles;
      hold_fired <= 1'b1;
    end else if (!hold_req) begin
      hold_fired <= 1'b0;
    end
  end

  // Output side: compare each accepted letter beat, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_letters.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, got %h/%b/%b", $time,
                 out_ch.char_out, out_ch.run_last, out_ch.count_clipped);
      end else begin
        exp_beat = expected_letters.pop_front();
        if (out_ch.char_out !== exp_beat.letter || out_ch.run_last !== exp_beat.is_last ||
            out_ch.count_clipped !== exp_beat.clipped) begin
          errors++;
          $display("%0t: letter mismatch: expected %h/%b/%b, got %h/%b/%b", $time,
                   exp_beat.letter, exp_beat.is_last, exp_beat.clipped,
                   out_ch.char_out, out_ch.run_last, out_ch.count_clipped);
        end
      end
    end
    if (hold_left != 0) out_ch.ready <= 1'b0;
    else if (no_idle)   out_ch.ready <= 1'b1;
    else                out_ch.ready <= ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_in    = '0;
    in_ch.string_end = 1'b0;
    out_ch.ready     = 1'b0;
    held_any         = 1'b0;
    step_beats       = 0;
    clear_decoder();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_runs();
    test_skipped_chars();
    test_count_saturation();
    test_random_strings();
    test_streaming();
    test_output_backpressure();

    in_ch.valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_letters.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
